// ===== rtl/mwc_random_bounded_defines.svh =====
// Assertion macros for the multiply-with-carry generator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MWC_RANDOM_BOUNDED_DEFINES_SVH
`define MWC_RANDOM_BOUNDED_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwc_random_bounded: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwc_random_bounded: next-cycle check failed");

`endif

// ===== rtl/mwcrb_pkg.sv =====
// Shared types, constants and helpers of the multiply-with-carry generator.
// No dependencies; used by the controller, the datapath and the top level.
package mwcrb_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] MWC_MULT  = 32'd2131995753;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;

  typedef enum logic [1:0] {
    FUNC_SEED    = 2'd0,
    FUNC_RAW     = 2'd1,
    FUNC_BOUNDED = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  need_draw;
    func_t func;
    logic  hit;
    logic  stuck;
    logic  out_free;
  } sts_t;

  // Smallest all-ones mask that covers the top set bit of m.
  function automatic logic [WORD_W-1:0] cover_mask(input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] k;
    k = m;
    k = k | (k >> 1);
    k = k | (k >> 2);
    k = k | (k >> 4);
    k = k | (k >> 8);
    k = k | (k >> 16);
    return k;
  endfunction

endpackage

// ===== rtl/mwcrb_ctrl.sv =====
// Controller state machine of the multiply-with-carry generator.
// Depends on mwcrb_pkg; drives the datapath through cmd_t, reads sts_t.
module mwcrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mwcrb_pkg::sts_t   sts,
  output mwcrb_pkg::cmd_t   cmd
);
  import mwcrb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_draw ? ST_EVAL : ST_DONE;
        end
      end
      ST_EVAL: begin
        if (sts.func == FUNC_RAW || sts.hit || sts.stuck) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EVAL: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/mwcrb_dp.sv =====
// Datapath of the multiply-with-carry generator: state, seed accumulators,
// the shared multiply-add, bound compare and the output register. Uses mwcrb_pkg.
module mwcrb_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  mwcrb_pkg::cmd_t  cmd,
  output mwcrb_pkg::sts_t  sts,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_seed_byte,
  input  logic             in_seed_last,
  input  logic [31:0]      in_bound,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_value,
  output logic             out_status
);
  import mwcrb_pkg::*;

  // Generator and seed state.
  logic [WORD_W-1:0] gen_value_r, gen_value_nxt;
  logic [WORD_W-1:0] gen_carry_r, gen_carry_nxt;
  logic [WORD_W-1:0] seed_low_r, seed_low_nxt;
  logic [WORD_W-1:0] seed_high_r, seed_high_nxt;
  logic [2:0]        seed_pos_r, seed_pos_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [2*WORD_W-1:0] prod_r, prod_nxt;
  logic [WORD_W-1:0]   mask_r, mask_nxt;
  logic [WORD_W-1:0]   bound_r, bound_nxt;
  func_t               func_r, func_nxt;
  logic [WORD_W-1:0]   res_value_r, res_value_nxt;
  logic                res_status_r, res_status_nxt;
  logic [WORD_W-1:0]   out_value_r, out_value_nxt;
  logic                out_status_r, out_status_nxt;

  func_t             in_func_t;
  logic [WORD_W-1:0] mul_w, mul_c;
  logic [WORD_W-1:0] prod_lo, prod_hi, masked;
  logic [WORD_W-1:0] shifted, acc_low, acc_high, inst_carry;
  logic              hit, stuck, out_free;

  assign in_func_t = func_t'(in_func);
  assign prod_lo   = prod_r[WORD_W-1:0];
  assign prod_hi   = prod_r[2*WORD_W-1:WORD_W];
  assign masked    = prod_lo & mask_r;
  assign hit       = masked < bound_r;
  assign stuck     = (prod_lo == WORD_ONES) && (prod_hi == (MWC_MULT - 32'd1));
  assign out_free  = !out_valid_r || out_ready;

  // One multiply-add, fed by the installed state on accept and by the
  // previous draw while redrawing.
  assign mul_w    = cmd.accept ? gen_value_r : prod_lo;
  assign mul_c    = cmd.accept ? gen_carry_r : prod_hi;
  assign prod_nxt = (2*WORD_W)'(MWC_MULT) * (2*WORD_W)'(mul_w) + (2*WORD_W)'(mul_c);

  // Seed byte placement and accumulation.
  assign shifted  = WORD_W'(in_seed_byte) << {seed_pos_r[1:0], 3'b000};
  assign acc_low  = seed_low_r + (seed_pos_r[2] ? '0 : shifted);
  assign acc_high = seed_high_r + (seed_pos_r[2] ? shifted : '0);
  assign inst_carry =
    (((acc_low == '0) && (acc_high == '0)) ||
     ((acc_low == WORD_ONES) && (acc_high == (MWC_MULT - 32'd1)))) ?
    acc_high + 32'd1 : acc_high;

  always_comb begin
    gen_value_nxt  = gen_value_r;
    gen_carry_nxt  = gen_carry_r;
    seed_low_nxt   = seed_low_r;
    seed_high_nxt  = seed_high_r;
    seed_pos_nxt   = seed_pos_r;
    mask_nxt       = mask_r;
    bound_nxt      = bound_r;
    func_nxt       = func_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    if (cmd.accept) begin
      func_nxt       = in_func_t;
      bound_nxt      = in_bound;
      mask_nxt       = cover_mask(in_bound);
      res_value_nxt  = '0;
      res_status_nxt = (in_func_t == FUNC_BOUNDED) && (in_bound == '0);
      if (in_func_t == FUNC_SEED) begin
        if (in_seed_last) begin
          gen_value_nxt = acc_low;
          gen_carry_nxt = inst_carry;
          seed_low_nxt  = '0;
          seed_high_nxt = '0;
          seed_pos_nxt  = '0;
        end else begin
          seed_low_nxt  = acc_low;
          seed_high_nxt = acc_high;
          seed_pos_nxt  = seed_pos_r + 3'd1;
        end
      end
    end
    if (cmd.step) begin
      gen_value_nxt = prod_lo;
      gen_carry_nxt = prod_hi;
      if (func_r == FUNC_RAW) begin
        res_value_nxt  = prod_lo;
        res_status_nxt = 1'b0;
      end else begin
        res_value_nxt  = hit ? masked : '0;
        res_status_nxt = !hit && stuck;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = res_value_r;
      out_status_nxt = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_value_r <= '0;
      gen_carry_r <= 32'd1;
      seed_low_r  <= '0;
      seed_high_r <= '0;
      seed_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gen_value_r <= gen_value_nxt;
      gen_carry_r <= gen_carry_nxt;
      seed_low_r  <= seed_low_nxt;
      seed_high_r <= seed_high_nxt;
      seed_pos_r  <= seed_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    mask_r       <= mask_nxt;
    bound_r      <= bound_nxt;
    func_r       <= func_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign sts.need_draw = (in_func_t == FUNC_RAW) ||
                         ((in_func_t == FUNC_BOUNDED) && (in_bound != '0));
  assign sts.func      = func_r;
  assign sts.hit       = hit;
  assign sts.stuck     = stuck;
  assign sts.out_free  = out_free;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ===== rtl/mwc_random_bounded.sv =====
// Top level of the multiply-with-carry generator with bounded draws.
// Instantiates mwcrb_ctrl and mwcrb_dp; uses mwcrb_pkg and the assertion header.
//
// This block is a 32-bit multiply-with-carry generator (multiplier 2131995753)
// that takes one request per input beat and answers each with exactly one
// output beat. in_func selects the request: 0 absorbs in_seed_byte into the
// seed (the beat with in_seed_last installs the new state), 1 returns a raw
// 32-bit draw, 2 returns a draw below in_bound by masking and redrawing, and
// 3 is a no-op that answers zero. A zero bound, or a generator parked on its
// fixed point where no draw can succeed, answers value 0 with out_status 1.
// Requests are handled one at a time. A seed beat, a no-op or a zero bound
// goes from accept straight to the done state, which hands its result to the
// output register once that register is free; a raw draw first passes through
// the draw state; a bounded draw stays in the draw state until a draw falls
// below the bound or the generator is found stuck, and rejection keeps the
// expected number of draws below two. The single registered 32-by-32
// multiply-add produces one draw per cycle while the draw loop runs. The
// output register lets the next request be accepted while a finished result
// beat still waits for out_ready.
`include "mwc_random_bounded_defines.svh"

module mwc_random_bounded (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_seed_byte,
  input  logic        in_seed_last,
  input  logic [31:0] in_bound,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic        out_status
);
  import mwcrb_pkg::*;

  // Command and status bundles between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller sequences accept, the draw loop and the hand-off to the
  // output register.
  mwcrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the generator state, seed accumulators, the shared
  // multiply-add and the output register.
  mwcrb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_func),
    .in_seed_byte (in_seed_byte),
    .in_seed_last (in_seed_last),
    .in_bound     (in_bound),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_status   (out_status)
  );

  // The block is not ready again in the cycle after a beat is accepted.
  `MWC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // Every error answer carries a zero value.
  `MWC_ASSERT_NOW(a_error_zero_value, out_valid && out_status, out_value == 32'd0)
  // The draw loop never runs while the block offers to accept.
  `MWC_ASSERT_NOW(a_step_not_ready, cmd.step, !in_ready)

endmodule

// ===== sim/tb_mwc_random_bounded.sv =====
// Self-checking testbench for the multiply-with-carry generator mwc_random_bounded.
// Depends on mwcrb_pkg and the RTL of the block; a built-in predictor provides expected beats.
`timescale 1ns / 1ps

module tb_mwc_random_bounded;
  import mwcrb_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 325;
  localparam int unsigned SETTLE_CYCLES   = 20;

  // Carry of the fixed point (all-ones value, carry MWC_MULT-1), and the carry
  // that, paired with value 0xfffffffe, steps straight onto that fixed point.
  localparam logic [31:0] STUCK_CARRY     = MWC_MULT - 32'd1;
  localparam logic [31:0] PRE_STUCK_CARRY = MWC_MULT + STUCK_CARRY;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
  } draw_result_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func      = FUNC_NONE;
  logic [7:0]  in_seed_byte = 8'd0;
  logic        in_seed_last = 1'b0;
  logic [31:0] in_bound     = 32'd0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] out_value;
  logic        out_status;

  mwc_random_bounded u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_seed_byte (in_seed_byte),
    .in_seed_last (in_seed_last),
    .in_bound     (in_bound),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_status   (out_status)
  );

  // 4 ns clock: two ns high, two ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Generator and seed state as the block should hold it after every accepted beat.
  logic [31:0] gen_w;
  logic [31:0] gen_c;
  logic [31:0] seed_lo;
  logic [31:0] seed_hi;
  logic [2:0]  seed_pos;

  // Results owed by the block, oldest at the front.
  draw_result_t expected_draws[$];
  draw_result_t oldest_draw;

  // Percent chance per cycle that the sender holds off / the receiver stalls.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned n_errors   = 0;
  int unsigned n_sent     = 0;
  int unsigned n_results  = 0;
  int unsigned n_raw      = 0;
  int unsigned n_bounded  = 0;
  int unsigned n_redraws  = 0;
  int unsigned n_stuck    = 0;
  int unsigned n_zero     = 0;
  int unsigned n_installs = 0;
  int unsigned n_noop     = 0;

  // One multiply-add of the generator: the low word is the new value and the
  // drawn number, the high word the new carry.
  function automatic logic [31:0] mwc_advance();
    logic [63:0] prod;
    prod  = {32'd0, MWC_MULT} * {32'd0, gen_w} + {32'd0, gen_c};
    gen_w = prod[31:0];
    gen_c = prod[63:32];
    return gen_w;
  endfunction

  // All-ones mask up to and including the highest set bit of the bound.
  function automatic logic [31:0] bound_mask(input logic [31:0] b);
    logic [31:0] m;
    m = 32'd0;
    for (int i = 0; i < 32; i++)
      if (b[i]) m = 32'hffff_ffff >> (31 - i);
    return m;
  endfunction

  // Applies one accepted request to the predicted state and queues the result
  // that the block owes for it.
  function automatic void mwc_predict(input func_t f, input logic [7:0] sb,
                                      input logic sl, input logic [31:0] bnd);
    draw_result_t res;
    logic [31:0]  shifted;
    logic [31:0]  mask;
    logic [31:0]  r;
    logic         done;
    res = '0;
    case (f)
      FUNC_SEED: begin
        shifted = {24'd0, sb} << {seed_pos[1:0], 3'b000};
        if (!seed_pos[2]) seed_lo = seed_lo + shifted;
        else              seed_hi = seed_hi + shifted;
        seed_pos = seed_pos + 3'd1;
        if (sl) begin
          // A degenerate pair would leave the generator stuck, so the carry is nudged.
          if ((seed_lo == 32'd0 && seed_hi == 32'd0) ||
              (seed_lo == WORD_ONES && seed_hi == STUCK_CARRY))
            seed_hi = seed_hi + 32'd1;
          gen_w    = seed_lo;
          gen_c    = seed_hi;
          seed_lo  = 32'd0;
          seed_hi  = 32'd0;
          seed_pos = 3'd0;
          n_installs++;
        end
      end
      FUNC_RAW: begin
        res.value = mwc_advance();
        n_raw++;
      end
      FUNC_BOUNDED: begin
        n_bounded++;
        if (bnd == 32'd0) begin
          res.status = 1'b1;
          n_zero++;
        end else begin
          mask = bound_mask(bnd);
          done = 1'b0;
          while (!done) begin
            r = mwc_advance() & mask;
            if (r < bnd) begin
              res.value = r;
              done      = 1'b1;
            end else if (gen_w == WORD_ONES && gen_c == STUCK_CARRY) begin
              // Parked on the fixed point: no redraw can ever fall below the bound.
              res.status = 1'b1;
              done       = 1'b1;
              n_stuck++;
            end else begin
              n_redraws++;
            end
          end
        end
      end
      default: n_noop++;
    endcase
    expected_draws.push_back(res);
  endfunction

  // Sends one request beat. Must be entered at a rising edge. Returns at the
  // edge where the beat was taken, with valid left high; the next call or the
  // caller decides whether it drops.
  task automatic send_request(input func_t f, input logic [7:0] sb, input logic sl,
                              input logic [31:0] bnd);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_seed_byte <= sb;
    in_seed_last <= sl;
    in_bound     <= bnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mwc_predict(f, sb, sl, bnd);
    n_sent++;
  endtask

  // Holds the sender off until every owed result has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_draws.size() != 0) @(posedge clk);
  endtask

  // Seeds a full value/carry pair as eight bytes, low byte first. Optionally a
  // raw draw is slipped in after the value half, which must use the old state.
  task automatic seed_pair(input logic [31:0] w, input logic [31:0] c,
                           input logic mid_draw);
    logic [63:0] pair;
    pair = {c, w};
    for (int i = 0; i < 8; i++) begin
      send_request(FUNC_SEED, pair[8*i +: 8], i == 7, $urandom);
      if (mid_draw && i == 3) send_request(FUNC_RAW, 8'($urandom), 1'($urandom), $urandom);
    end
  endtask

  // Straight out of reset the generator holds value 0 and carry 1, so the
  // first draw is 1 and the second is the multiplier itself.
  task automatic test_reset_state();
    send_request(FUNC_RAW, 8'h00, 1'b0, 32'd0);
    send_request(FUNC_RAW, 8'hff, 1'b1, 32'hffff_ffff);
  endtask

  // The unused selector, a raw draw, and bounded draws at the bound extremes:
  // zero (error), one (always 0), only the top bit set, and all ones.
  task automatic test_functions();
    send_request(FUNC_NONE, 8'hff, 1'b1, 32'hffff_ffff);
    send_request(FUNC_BOUNDED, 8'h00, 1'b0, 32'd0);
    send_request(FUNC_BOUNDED, 8'h00, 1'b0, 32'd1);
    send_request(FUNC_BOUNDED, 8'h00, 1'b0, 32'h8000_0000);
    send_request(FUNC_BOUNDED, 8'h00, 1'b0, 32'hffff_ffff);
    send_request(FUNC_RAW, 8'h00, 1'b0, 32'd0);
  endtask

  // Both degenerate seeds. A single zero byte flagged last installs (0, 0),
  // which must come out with carry 1; the all-ones/fixed-point pair must come
  // out with its carry bumped. A draw after each shows the installed state.
  task automatic test_seeding();
    send_request(FUNC_SEED, 8'h00, 1'b1, 32'd0);
    send_request(FUNC_RAW, 8'h00, 1'b0, 32'd0);
    seed_pair(WORD_ONES, STUCK_CARRY, 1'b0);
    send_request(FUNC_RAW, 8'h00, 1'b0, 32'd0);
  endtask

  // Seeds the one state that steps onto the fixed point. After one raw draw the
  // generator sits there: raw draws keep returning all ones and every bounded
  // draw must give up with an error. A draw in the middle of the seed checks
  // that a seed in progress leaves the running generator alone.
  task automatic test_stuck_point();
    seed_pair(WORD_ONES - 32'd1, PRE_STUCK_CARRY, 1'b1);
    send_request(FUNC_RAW, 8'h00, 1'b0, 32'd0);
    send_request(FUNC_BOUNDED, 8'h00, 1'b0, 32'd5);
    send_request(FUNC_BOUNDED, 8'h00, 1'b0, 32'hffff_ffff);
    send_request(FUNC_RAW, 8'h00, 1'b0, 32'd0);
    // The sender stays quiet until the block has caught up completely.
    wait_drained();
    seed_pair($urandom, $urandom, 1'b0);
  endtask

  // Bounds of random bit length, so the rejection mask takes every width.
  function automatic logic [31:0] random_bound();
    int unsigned width;
    width = $urandom_range(32, 1);
    return $urandom >> (32 - width);
  endfunction

  // A seed of 1 to 12 bytes, so the byte position also wraps past eight. Draws
  // may be mixed in, and now and then the closing byte is left off so that the
  // next seed keeps adding into the same accumulators.
  task automatic send_seed_burst();
    int unsigned len;
    logic        open_end;
    len      = $urandom_range(12, 1);
    open_end = ($urandom_range(9) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_request(FUNC_SEED, 8'($urandom), (i == len - 1) && !open_end, $urandom);
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1) == 0)
          send_request(FUNC_RAW, 8'($urandom), 1'($urandom), $urandom);
        else
          send_request(FUNC_BOUNDED, 8'($urandom), 1'($urandom), random_bound());
      end
    end
  endtask

  // Mostly draws and complete seeds, with some no-ops, zero bounds and stray
  // seed bytes as noise. Halfway through, the sender waits for a full drain.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle,
                                     input int unsigned stall);
    int unsigned target;
    int unsigned halfway;
    int unsigned pick;
    logic        drained;
    idle_pct  = idle;
    stall_pct = stall;
    target    = n_sent + n_items;
    halfway   = n_sent + n_items / 2;
    drained   = 1'b0;
    while (n_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 40)
        send_request(FUNC_RAW, 8'($urandom), 1'($urandom), $urandom);
      else if (pick < 75)
        send_request(FUNC_BOUNDED, 8'($urandom), 1'($urandom), random_bound());
      else if (pick < 90)
        send_seed_burst();
      else if (pick < 95)
        send_request(FUNC_NONE, 8'($urandom), 1'($urandom), $urandom);
      else if (pick < 97)
        send_request(FUNC_BOUNDED, 8'($urandom), 1'($urandom), 32'd0);
      else
        send_request(FUNC_SEED, 8'($urandom), 1'b0, $urandom);
      if (!drained && n_sent >= halfway) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  // Result side: every beat taken is compared with the oldest expectation, and
  // the stall decision for the next cycle is made afterwards.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_draws.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with nothing expected: value %h status %b",
                 $time, out_value, out_status);
      end else begin
        oldest_draw = expected_draws.pop_front();
        if (out_value !== oldest_draw.value) begin
          n_errors++;
          $display("%0t: value mismatch: expected %h actual %h",
                   $time, oldest_draw.value, out_value);
        end
        if (out_status !== oldest_draw.status) begin
          n_errors++;
          $display("%0t: status mismatch: expected %b actual %b",
                   $time, oldest_draw.status, out_status);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    gen_w    = 32'd0;
    gen_c    = 32'd1;
    seed_lo  = 32'd0;
    seed_hi  = 32'd0;
    seed_pos = 3'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_functions();
    test_seeding();
    test_stuck_point();
    test_random_traffic(ITEMS_PER_PHASE, 0, 0);
    test_random_traffic(ITEMS_PER_PHASE, 69, 0);
    test_random_traffic(ITEMS_PER_PHASE, 0, 69);
    test_random_traffic(ITEMS_PER_PHASE, 17, 17);

    // Let everything owed arrive, then watch a while longer for stray beats.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d raw draws, %0d bounded draws",
             n_sent, n_results, n_raw, n_bounded);
    $display("(%0d redraws, %0d stuck, %0d zero bounds), %0d seeds installed, %0d no-ops.",
             n_redraws, n_stuck, n_zero, n_installs, n_noop);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run of this stimulus.
  initial begin
    #4_000_000;
    $display("Run timed out with %0d results still outstanding.", expected_draws.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
